// ===== sv/shadow_validity_bitmap_defines.svh =====
// ----------------------------------------------------------------------------
// shadow_validity_bitmap_defines.svh
// Assertion macros for the shadow validity bitmap. They expect clk and
// arst_n to be visible where they are used.
// ----------------------------------------------------------------------------
`ifndef SHADOW_VALIDITY_BITMAP_DEFINES_SVH
`define SHADOW_VALIDITY_BITMAP_DEFINES_SVH

// same-cycle implication
`define SVB_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shadow validity bitmap: same-cycle check failed");

// next-cycle implication
`define SVB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shadow validity bitmap: next-cycle check failed");

`endif

// ===== sv/svb_pkg.sv =====
// ----------------------------------------------------------------------------
// svb_pkg
// Types and constants of the shadow validity bitmap.
// ----------------------------------------------------------------------------
package svb_pkg;

	localparam int MEM_BYTES        = 65536;
	localparam int WORD_BITS        = 64;
	localparam int MAX_ACCESS_BYTES = 8;
	localparam int BITS_PER_BYTE    = 8;

	localparam int SHADOW_WORDS = MEM_BYTES * BITS_PER_BYTE / WORD_BITS;
	localparam int WORD_AW      = $clog2(SHADOW_WORDS);
	localparam int BPW_AW       = $clog2(WORD_BITS / BITS_PER_BYTE);
	localparam int POS_W        = $clog2(WORD_BITS);
	localparam int ADDR_W       = 16;
	localparam int BOFF_W       = 3;
	localparam int SIZE_W       = 4;
	localparam int NBITS_W      = 7;
	localparam int OP_W         = 3;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 88;

	typedef enum logic [OP_W-1:0] {
		OP_SET_REGION   = 3'd0,
		OP_CLEAR_REGION = 3'd1,
		OP_CHECK_REGION = 3'd2,
		OP_SET_BIT      = 3'd3,
		OP_CLEAR_BIT    = 3'd4,
		OP_CHECK_BIT    = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR0,
		ST_WR1,
		ST_CHK
	} state_t;

	function automatic logic [WORD_BITS-1:0] ones_mask(input logic [NBITS_W-1:0] n);
		logic [WORD_BITS-1:0] m;
		if (n >= NBITS_W'(WORD_BITS)) begin
			m = '1;
		end else begin
			m = (WORD_BITS'(1) << n) - WORD_BITS'(1);
		end
		return m;
	endfunction

endpackage

// ===== sv/shadow_validity_bitmap.sv =====
// ----------------------------------------------------------------------------
// shadow_validity_bitmap
// One validity bit per memory bit, held in 64-bit shadow words in a RAM.
// ----------------------------------------------------------------------------
// Input channel s_*: one transaction per operation. s_tuser carries the op
// code (set/clear/check region, set/clear/check bit; codes 6 and 7 are
// dropped). s_tdata carries address, bit offset and region size.
// Output channel m_*: one transaction per check, with the undefined flag in
// m_tuser and the validity mask, echoed address and bit count in m_tdata.
// A region spans at most two shadow words. The accept cycle issues the first
// word read; state WR0 then read-modify-writes that word and WR1 the second
// one, if needed, through the single RAM port pair (a check only reads), and
// a check adds state CHK for the shift/mask unit. Out of reset the block
// sweeps all 8192 shadow words to invalid, one per cycle, and holds s_tready
// low until the sweep is done. A stalled receiver keeps the result in the
// output register; a new item can still be taken, and a check that finishes
// meanwhile waits until the register frees up.
// ----------------------------------------------------------------------------
module shadow_validity_bitmap (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// address[15:0], bit_offset[18:16], size_bytes[22:19], zero fill
	input  logic [svb_pkg::IN_DATA_W-1:0]    s_tdata,
	// op[2:0]
	input  logic [svb_pkg::OP_W-1:0]         s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// valid_mask[63:0], report_address[79:64], report_bits[86:80], zero fill
	output logic [svb_pkg::OUT_DATA_W-1:0]   m_tdata,
	// undefined[0]
	output logic [0:0]                       m_tuser
);

	import svb_pkg::*;

	`include "shadow_validity_bitmap_defines.svh"

	state_t state_q, state_d;

	logic [WORD_AW-1:0]   clr_q;
	logic [WORD_AW-1:0]   word_q;
	logic [POS_W-1:0]     pos_q;
	logic [NBITS_W-1:0]   nbits_q;
	logic [WORD_BITS-1:0] lomask_q, himask_q;
	logic                 need_hi_q, set_q, check_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [WORD_BITS-1:0] d0_q, d1_q;
	logic                 m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic                 m_undef_q;

	// decode of incoming transaction
	op_t                    acc_op;
	logic [ADDR_W-1:0]      acc_addr;
	logic [BOFF_W-1:0]      acc_boff;
	logic [SIZE_W-1:0]      acc_size, acc_size_sat;
	logic                   acc_bit_op, acc_set, acc_check, acc_known;
	logic [NBITS_W-1:0]     acc_nbits;
	logic [POS_W-1:0]       acc_pos;
	logic [2*WORD_BITS-1:0] acc_win;

	always_comb begin
		acc_op   = op_t'(s_tuser);
		acc_addr = s_tdata[ADDR_W-1:0];
		acc_boff = s_tdata[ADDR_W+BOFF_W-1:ADDR_W];
		acc_size = s_tdata[ADDR_W+BOFF_W+SIZE_W-1:ADDR_W+BOFF_W];
		acc_bit_op = 1'b0;
		acc_set    = 1'b0;
		acc_check  = 1'b0;
		acc_known  = 1'b1;
		unique case (acc_op)
			OP_SET_REGION:   acc_set = 1'b1;
			OP_CLEAR_REGION: ;
			OP_CHECK_REGION: acc_check = 1'b1;
			OP_SET_BIT: begin
				acc_bit_op = 1'b1;
				acc_set    = 1'b1;
			end
			OP_CLEAR_BIT:    acc_bit_op = 1'b1;
			OP_CHECK_BIT: begin
				acc_bit_op = 1'b1;
				acc_check  = 1'b1;
			end
			default:         acc_known = 1'b0;
		endcase
		acc_size_sat = (acc_size > SIZE_W'(MAX_ACCESS_BYTES)) ?
			SIZE_W'(MAX_ACCESS_BYTES) : acc_size;
		acc_nbits = acc_bit_op ? NBITS_W'(1) : {acc_size_sat, 3'b000};
		acc_pos   = {acc_addr[BPW_AW-1:0], acc_bit_op ? acc_boff : 3'b000};
		acc_win   = {{WORD_BITS{1'b0}}, ones_mask(acc_nbits)} << acc_pos;
	end

	// shared shift/mask unit for the check result
	logic [2*WORD_BITS-1:0] chk_shift;
	logic [WORD_BITS-1:0]   chk_ones, chk_mask;
	logic                   chk_undef;

	always_comb begin
		chk_shift = {d1_q, d0_q} >> pos_q;
		chk_ones  = ones_mask(nbits_q);
		chk_mask  = chk_shift[WORD_BITS-1:0] & chk_ones;
		chk_undef = chk_mask != chk_ones;
	end

	// RAM
	logic                 ram_we;
	logic [WORD_AW-1:0]   ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
	logic [WORD_BITS-1:0] cur_mask;
	logic                 out_load, out_free;

	svb_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(SHADOW_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_free = !m_tvalid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == WORD_AW'(SHADOW_WORDS - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (s_tvalid && acc_known) state_d = ST_WR0;
			ST_WR0: begin
				if (need_hi_q)    state_d = ST_WR1;
				else if (check_q) state_d = ST_CHK;
				else              state_d = ST_IDLE;
			end
			ST_WR1:   state_d = check_q ? ST_CHK : ST_IDLE;
			ST_CHK:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = word_q;
		ram_raddr = word_q + WORD_AW'(1);
		cur_mask  = lomask_q;
		out_load  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			ST_IDLE: begin
				s_tready  = 1'b1;
				ram_raddr = acc_addr[ADDR_W-1:BPW_AW];
			end
			ST_WR0:   ram_we = !check_q;
			ST_WR1: begin
				ram_we    = !check_q;
				ram_waddr = word_q + WORD_AW'(1);
				cur_mask  = himask_q;
			end
			ST_CHK:   out_load = out_free;
			default:  ;
		endcase
		if (state_q == ST_CLEAR) begin
			ram_wdata = '0;
		end else begin
			ram_wdata = (ram_rdata & ~cur_mask) | (set_q ? cur_mask : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + WORD_AW'(1);
			if (out_load)             m_tvalid_q <= 1'b1;
			else if (m_tready)        m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			word_q    <= acc_addr[ADDR_W-1:BPW_AW];
			pos_q     <= acc_pos;
			nbits_q   <= acc_nbits;
			lomask_q  <= acc_win[WORD_BITS-1:0];
			himask_q  <= acc_win[2*WORD_BITS-1:WORD_BITS];
			need_hi_q <= |acc_win[2*WORD_BITS-1:WORD_BITS];
			set_q     <= acc_set;
			check_q   <= acc_check;
			addr_q    <= acc_addr;
		end
		if (state_q == ST_WR0) d0_q <= ram_rdata;
		if (state_q == ST_WR1) d1_q <= ram_rdata;
		if (out_load) begin
			m_undef_q <= chk_undef;
			m_data_q  <= {1'b0, nbits_q, addr_q, chk_mask};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_undef_q;

	`SVB_ASSERT_IMPL(a_no_accept_in_clear, state_q == ST_CLEAR, !s_tready)
	`SVB_ASSERT_IMPL(a_check_no_write,
		(state_q == ST_WR0 || state_q == ST_WR1) && check_q, !ram_we)
	`SVB_ASSERT_IMPL(a_hi_word_needed, state_q == ST_WR1, need_hi_q)
	`SVB_ASSERT_NEXT(a_result_waits,
		state_q == ST_CHK && m_tvalid_q && !m_tready, state_q == ST_CHK)

endmodule

// ===== sv/svb_ram.sv =====
// ----------------------------------------------------------------------------
// svb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module svb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== bench/shadow_validity_checker.sv =====
// ----------------------------------------------------------------------------
// shadow_validity_checker
// Watches both streams of the shadow validity bitmap. It keeps its own copy
// of the validity store, applies each accepted operation to it in order,
// queues the expected result of every check and compares each output
// transaction field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module shadow_validity_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [svb_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [svb_pkg::OP_W-1:0]       s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [svb_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic [0:0]                     m_tuser,
	output int                             fail_count,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import svb_pkg::*;

	localparam int BIT_IDX_W = $clog2(MEM_BYTES * BITS_PER_BYTE);

	typedef struct packed {
		logic                 undefined;
		logic [WORD_BITS-1:0] valid_mask;
		logic [ADDR_W-1:0]    address;
		logic [NBITS_W-1:0]   report_bits;
	} check_result_t;

	logic [WORD_BITS-1:0] shadow_model [SHADOW_WORDS];
	check_result_t        pending_checks [$];

	task automatic note_mismatch(input string what, input logic [WORD_BITS-1:0] got,
			input logic [WORD_BITS-1:0] want);
		$display("%0t ns: check mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	// updates the store; returns 1 with the expected result for a check
	function automatic bit apply_shadow_op(input logic [OP_W-1:0] op,
			input logic [ADDR_W-1:0] addr, input logic [BOFF_W-1:0] boff,
			input logic [SIZE_W-1:0] size, output check_result_t res);
		int nbits;
		logic [BIT_IDX_W-1:0] idx;
		bit hit;
		res = '0;
		res.address = addr;
		nbits = ((size > MAX_ACCESS_BYTES) ? MAX_ACCESS_BYTES : int'(size)) * BITS_PER_BYTE;
		case (op) inside
			OP_SET_REGION, OP_CLEAR_REGION: begin
				for (int i = 0; i < nbits; i++) begin
					idx = {addr, 3'b000} + BIT_IDX_W'(i);
					shadow_model[idx[BIT_IDX_W-1:POS_W]][idx[POS_W-1:0]] = (op == OP_SET_REGION);
				end
				return 1'b0;
			end
			OP_CHECK_REGION: begin
				for (int i = 0; i < nbits; i++) begin
					idx = {addr, 3'b000} + BIT_IDX_W'(i);
					hit = shadow_model[idx[BIT_IDX_W-1:POS_W]][idx[POS_W-1:0]];
					res.valid_mask[i] = hit;
					if (!hit) res.undefined = 1'b1;
				end
				res.report_bits = NBITS_W'(nbits);
				return 1'b1;
			end
			OP_SET_BIT, OP_CLEAR_BIT: begin
				idx = {addr, boff};
				shadow_model[idx[BIT_IDX_W-1:POS_W]][idx[POS_W-1:0]] = (op == OP_SET_BIT);
				return 1'b0;
			end
			OP_CHECK_BIT: begin
				idx = {addr, boff};
				hit = shadow_model[idx[BIT_IDX_W-1:POS_W]][idx[POS_W-1:0]];
				res.valid_mask[0] = hit;
				res.undefined = !hit;
				res.report_bits = NBITS_W'(1);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		check_result_t want;
		check_result_t got;
		if (!arst_n) begin
			foreach (shadow_model[w]) shadow_model[w] = '0;
			pending_checks.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (apply_shadow_op(s_tuser, s_tdata[15:0], s_tdata[18:16], s_tdata[22:19], want))
					pending_checks.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got.undefined   = m_tuser[0];
				got.valid_mask  = m_tdata[63:0];
				got.address     = m_tdata[79:64];
				got.report_bits = m_tdata[86:80];
				if (pending_checks.size() == 0) begin
					note_mismatch("result with no check pending", WORD_BITS'(got.address), '0);
				end else begin
					want = pending_checks.pop_front();
					if (got.undefined !== want.undefined)
						note_mismatch("undefined", WORD_BITS'(got.undefined),
							WORD_BITS'(want.undefined));
					if (got.valid_mask !== want.valid_mask)
						note_mismatch("valid_mask", got.valid_mask, want.valid_mask);
					if (got.address !== want.address)
						note_mismatch("report_address", WORD_BITS'(got.address),
							WORD_BITS'(want.address));
					if (got.report_bits !== want.report_bits)
						note_mismatch("report_bits", WORD_BITS'(got.report_bits),
							WORD_BITS'(want.report_bits));
				end
			end
			pending <= pending_checks.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the shadow validity bitmap: a directed pass over the region
// and bit operations, wrap past the last byte, empty and oversized regions
// and dropped op codes, then random operations clustered in small address
// windows so that checks see mixed valid and invalid bits. Both sides idle
// at random in the first two of three phases; the receiver once holds off
// long enough to stall the input. The checker module predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import svb_pkg::*;

	localparam logic [OP_W-1:0] OP_RESERVED_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RESERVED_7 = 3'd7;
	localparam int STALL_LIMIT   = 40000;
	localparam int HOLD_CYCLES   = 600;
	localparam int TAIL_CYCLES   = 16;
	localparam int PHASE_ITEMS   = 400;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [OP_W-1:0]       s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [0:0]            m_tuser;
	int                    fail_count;
	int                    pending;

	int                    tx_idle_pct;
	int                    rx_idle_pct;
	bit                    rx_hold_req;
	logic [ADDR_W-1:0]     hot_base;

	shadow_validity_bitmap DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	shadow_validity_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, or one long hold-off on request
	initial begin : receiver
		bit hold_done;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// ends the run when no transaction moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	task automatic drive_op(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
			input logic [BOFF_W-1:0] boff, input logic [SIZE_W-1:0] size);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, size, boff, addr};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
	endtask

	task automatic drain_checks();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic next_random_op(input bit checks_only);
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] addr;
		logic [SIZE_W-1:0] size;
		int r;
		r = $urandom_range(0, 99);
		if (checks_only)  op = (r < 50) ? OP_CHECK_REGION : OP_CHECK_BIT;
		else if (r < 20)  op = OP_SET_REGION;
		else if (r < 30)  op = OP_CLEAR_REGION;
		else if (r < 55)  op = OP_CHECK_REGION;
		else if (r < 67)  op = OP_SET_BIT;
		else if (r < 75)  op = OP_CLEAR_BIT;
		else if (r < 95)  op = OP_CHECK_BIT;
		else if (r < 97)  op = OP_RESERVED_6;
		else              op = OP_RESERVED_7;
		case ($urandom_range(0, 9))
			0:       addr = ADDR_W'($urandom_range(0, 65535));
			1:       addr = ADDR_W'(16'hFFF0 + $urandom_range(0, 15));
			2:       addr = ADDR_W'($urandom_range(0, 15));
			default: addr = ADDR_W'(hot_base + $urandom_range(0, 47));
		endcase
		r = $urandom_range(0, 99);
		if (r < 5)       size = '0;
		else if (r < 15) size = SIZE_W'($urandom_range(9, 15));
		else             size = SIZE_W'($urandom_range(1, 8));
		drive_op(op, addr, BOFF_W'($urandom_range(0, 7)), size);
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = OP_SET_REGION;
		rx_hold_req = 1'b0;
		tx_idle_pct = 35;
		rx_idle_pct = 62;
		hot_base    = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// fresh store reads all invalid
		drive_op(OP_CHECK_REGION, 16'h0000, 3'd0, 4'd8);
		drive_op(OP_CHECK_BIT,    16'hFFFF, 3'd7, 4'd0);
		drive_op(OP_SET_REGION,   16'h0000, 3'd7, 4'd8);
		drive_op(OP_CHECK_REGION, 16'h0000, 3'd0, 4'd8);
		// straddling the end of memory
		drive_op(OP_SET_REGION,   16'hFFFC, 3'd0, 4'd8);
		drive_op(OP_CHECK_REGION, 16'hFFFD, 3'd0, 4'd8);
		drive_op(OP_CLEAR_BIT,    16'h0003, 3'd5, 4'd15);
		drive_op(OP_CHECK_REGION, 16'h0000, 3'd0, 4'd8);
		drive_op(OP_CHECK_BIT,    16'h0003, 3'd5, 4'd0);
		drive_op(OP_SET_BIT,      16'h0003, 3'd5, 4'd0);
		drive_op(OP_CHECK_BIT,    16'h0003, 3'd5, 4'd15);
		// oversized size saturates
		drive_op(OP_SET_REGION,   16'h0105, 3'd0, 4'd15);
		drive_op(OP_CHECK_REGION, 16'h0103, 3'd0, 4'd12);
		// empty regions
		drive_op(OP_CHECK_REGION, 16'h0010, 3'd0, 4'd0);
		drive_op(OP_SET_REGION,   16'h0010, 3'd0, 4'd0);
		drive_op(OP_CLEAR_REGION, 16'h0000, 3'd0, 4'd0);
		drive_op(OP_CHECK_REGION, 16'h0010, 3'd0, 4'd8);
		// dropped op codes
		drive_op(OP_RESERVED_6,   16'h0000, 3'd0, 4'd8);
		drive_op(OP_RESERVED_7,   16'h0000, 3'd0, 4'd8);
		// across a shadow word boundary
		drive_op(OP_CLEAR_REGION, 16'h0006, 3'd0, 4'd3);
		drive_op(OP_CHECK_REGION, 16'h0004, 3'd0, 4'd8);
		drive_op(OP_CHECK_REGION, 16'hFFFF, 3'd0, 4'd1);
		drive_op(OP_CLEAR_REGION, 16'hFFFF, 3'd0, 4'd8);
		drive_op(OP_CHECK_REGION, 16'hFFF8, 3'd0, 4'd9);
		drain_checks();
		repeat (8) @(posedge clk);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0:       begin tx_idle_pct = 35; rx_idle_pct = 62; end
				1:       begin tx_idle_pct = 62; rx_idle_pct = 35; end
				default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 100 == 0) hot_base = ADDR_W'($urandom_range(0, 65535));
				if (phase == 0 && n == 200) begin
					rx_hold_req = 1'b1;
					repeat (24) next_random_op(1'b1);
				end
				next_random_op(1'b0);
			end
			drain_checks();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/svb_pkg.sv
sv/svb_ram.sv
sv/shadow_validity_bitmap.sv
bench/shadow_validity_checker.sv
bench/testbench.sv
